[src/i2c_rts_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_rts_pkg
// Types, codes and defaults shared by the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_rts_pkg;

    localparam int TIMEOUT_TICKS_DEFAULT = 400;

    // operation codes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // status codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    // ACK control codes
    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_DISABLE = 2'd1;
    localparam logic [1:0] ACK_ENABLE  = 2'd2;

    typedef enum logic [15:0] {
        PH_IDLE        = 16'h0001,
        PH_RD_SB1      = 16'h0002,
        PH_RD_ADDR1    = 16'h0004,
        PH_RD_BTF      = 16'h0008,
        PH_RD_SB2      = 16'h0010,
        PH_RD_ADDR_ONE = 16'h0020,
        PH_RD_ADDR_DMA = 16'h0040,
        PH_RD_DATA     = 16'h0080,
        PH_RD_STOP_ONE = 16'h0100,
        PH_RD_DMA      = 16'h0200,
        PH_RD_STOP_DMA = 16'h0400,
        PH_WR_SB       = 16'h0800,
        PH_WR_ADDR     = 16'h1000,
        PH_WR_DMA      = 16'h2000,
        PH_WR_BTF      = 16'h4000,
        PH_WR_STOP     = 16'h8000
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] transfer_length;
        logic       start_sent;
        logic       address_sent;
        logic       byte_finished;
        logic       receive_full;
        logic       dma_rx_complete;
        logic       dma_tx_complete;
        logic       stop_pending;
        logic [7:0] received_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       request_start;
        logic       send_valid;
        logic [7:0] send_value;
        logic [1:0] ack_change;
        logic       request_stop;
        logic       arm_receive_dma;
        logic       arm_transmit_dma;
        logic       dma_off;
        logic       data_valid;
        logic [7:0] data_value;
        logic       fail_flag;
    } rsp_item_t;

endpackage

`default_nettype wire

[src/i2c_rts_if.sv]
// ----------------------------------------------------------------------------
// i2c_rts_if
// Valid/ready channels for sequencer command and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2c_rts_cmd_if;
    import i2c_rts_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface i2c_rts_rsp_if;
    import i2c_rts_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/i2c_rts_step.sv]
// ----------------------------------------------------------------------------
// i2c_rts_step
// Phase state and one-item step logic of the transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rts_step #(
    parameter int TIMEOUT_TICKS = i2c_rts_pkg::TIMEOUT_TICKS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire i2c_rts_pkg::cmd_item_t item,
    output i2c_rts_pkg::rsp_item_t      result
);
    import i2c_rts_pkg::*;

    localparam int WT_W = $clog2(TIMEOUT_TICKS + 1);
    localparam logic [WT_W:0] TMO_LIMIT = (WT_W + 1)'(TIMEOUT_TICKS);
    // first stop check after a byte already hits the limit
    localparam bit TMO_FIRST = (TIMEOUT_TICKS == 1);

    phase_t            phase_reg, phase_next;
    logic [7:0]        target_address_reg, target_address_next;
    logic [7:0]        target_register_reg, target_register_next;
    logic [7:0]        byte_count_reg, byte_count_next;
    logic [WT_W-1:0]   wait_ticks_reg, wait_ticks_next;
    logic              failed_reg, failed_next;

    logic [WT_W:0]     tick_inc;
    logic              tick_tmo;
    logic              multi_byte;
    logic              is_start;
    logic              reject;
    logic              done_ok;
    logic              done_fail;

    assign tick_inc   = {1'b0, wait_ticks_reg} + (WT_W + 1)'(1);
    assign tick_tmo   = (tick_inc >= TMO_LIMIT);
    assign multi_byte = (byte_count_reg > 8'd1);
    assign is_start   = (item.operation == OP_READ) || (item.operation == OP_WRITE);

    always_comb
    begin
        result               = '0;
        phase_next           = phase_reg;
        target_address_next  = target_address_reg;
        target_register_next = target_register_reg;
        byte_count_next      = byte_count_reg;
        wait_ticks_next      = wait_ticks_reg;
        failed_next          = failed_reg;
        reject               = 1'b0;
        done_ok              = 1'b0;
        done_fail            = 1'b0;

        if (is_start)
        begin
            if (phase_reg != PH_IDLE)
            begin
                reject = 1'b1;
            end
            else
            begin
                target_address_next  = item.device_address;
                byte_count_next      = item.transfer_length;
                wait_ticks_next      = '0;
                result.request_start = 1'b1;
                if (item.operation == OP_READ)
                begin
                    target_register_next = item.register_address;
                    phase_next           = PH_RD_SB1;
                end
                else
                begin
                    target_register_next    = '0;
                    result.arm_transmit_dma = 1'b1;
                    phase_next              = PH_WR_SB;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_RD_SB1, PH_WR_SB:
                begin
                    if (item.start_sent)
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = target_address_reg;
                        phase_next = (phase_reg == PH_RD_SB1) ? PH_RD_ADDR1 : PH_WR_ADDR;
                    end
                    else
                    begin
                        wait_ticks_next = tick_inc[WT_W-1:0];
                        done_fail       = tick_tmo;
                    end
                end
                PH_RD_ADDR1:
                begin
                    if (item.address_sent)
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = target_register_reg;
                        phase_next        = PH_RD_BTF;
                    end
                end
                PH_RD_BTF:
                begin
                    if (item.byte_finished)
                    begin
                        result.arm_receive_dma = multi_byte;
                        result.request_start   = 1'b1;
                        wait_ticks_next        = '0;
                        phase_next             = PH_RD_SB2;
                    end
                end
                PH_RD_SB2:
                begin
                    if (item.start_sent)
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = target_address_reg | 8'h01;
                        phase_next = multi_byte ? PH_RD_ADDR_DMA : PH_RD_ADDR_ONE;
                    end
                    else
                    begin
                        wait_ticks_next = tick_inc[WT_W-1:0];
                        done_fail       = tick_tmo;
                    end
                end
                PH_RD_ADDR_ONE:
                begin
                    if (item.address_sent)
                    begin
                        result.ack_change   = ACK_DISABLE;
                        result.request_stop = 1'b1;
                        phase_next          = PH_RD_DATA;
                    end
                end
                PH_RD_ADDR_DMA:
                begin
                    if (item.address_sent)
                    begin
                        phase_next = PH_RD_DMA;
                    end
                end
                PH_RD_DATA:
                begin
                    if (item.receive_full)
                    begin
                        result.data_valid = 1'b1;
                        result.data_value = item.received_byte;
                        phase_next        = PH_RD_STOP_ONE;
                        if (item.stop_pending)
                        begin
                            wait_ticks_next = WT_W'(1);
                            done_fail       = TMO_FIRST;
                        end
                        else
                        begin
                            wait_ticks_next   = '0;
                            result.ack_change = ACK_ENABLE;
                            done_ok           = 1'b1;
                        end
                    end
                end
                PH_RD_STOP_ONE:
                begin
                    if (item.stop_pending)
                    begin
                        wait_ticks_next = tick_inc[WT_W-1:0];
                        done_fail       = tick_tmo;
                    end
                    else
                    begin
                        result.ack_change = ACK_ENABLE;
                        done_ok           = 1'b1;
                    end
                end
                PH_RD_DMA, PH_WR_BTF:
                begin
                    if ((phase_reg == PH_RD_DMA) ? item.dma_rx_complete : item.byte_finished)
                    begin
                        result.request_stop = 1'b1;
                        phase_next = (phase_reg == PH_RD_DMA) ? PH_RD_STOP_DMA : PH_WR_STOP;
                        if (item.stop_pending)
                        begin
                            wait_ticks_next = WT_W'(1);
                            done_fail       = TMO_FIRST;
                        end
                        else
                        begin
                            wait_ticks_next = '0;
                            result.dma_off  = 1'b1;
                            done_ok         = 1'b1;
                        end
                    end
                end
                PH_RD_STOP_DMA, PH_WR_STOP:
                begin
                    if (item.stop_pending)
                    begin
                        wait_ticks_next = tick_inc[WT_W-1:0];
                        done_fail       = tick_tmo;
                    end
                    else
                    begin
                        result.dma_off = 1'b1;
                        done_ok        = 1'b1;
                    end
                end
                PH_WR_ADDR:
                begin
                    if (item.address_sent)
                    begin
                        phase_next = PH_WR_DMA;
                    end
                end
                PH_WR_DMA:
                begin
                    if (item.dma_tx_complete)
                    begin
                        phase_next = PH_WR_BTF;
                    end
                end
                default:
                begin
                    // idle poll: nothing to do
                end
            endcase
        end

        if (done_fail)
        begin
            failed_next     = 1'b1;
            phase_next      = PH_IDLE;
            wait_ticks_next = '0;
            result.status   = ST_FAILED;
        end
        else if (done_ok)
        begin
            phase_next      = PH_IDLE;
            wait_ticks_next = '0;
            result.status   = ST_IDLE;
        end
        else if (reject)
        begin
            result.status = ST_REJECT;
        end
        else if (phase_next == PH_IDLE)
        begin
            result.status = ST_IDLE;
        end
        else
        begin
            result.status = failed_reg ? ST_FAILED : ST_BUSY;
        end
        result.fail_flag = failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            target_address_reg  <= '0;
            target_register_reg <= '0;
            byte_count_reg      <= '0;
            wait_ticks_reg      <= '0;
            failed_reg          <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            target_address_reg  <= target_address_next;
            target_register_reg <= target_register_next;
            byte_count_reg      <= byte_count_next;
            wait_ticks_reg      <= wait_ticks_next;
            failed_reg          <= failed_next;
        end
    end

endmodule

`default_nettype wire

[src/i2c_rts_skid.sv]
// ----------------------------------------------------------------------------
// i2c_rts_skid
// Response register plus one skid entry; push side stays open while a
// finished item waits.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rts_skid (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire i2c_rts_pkg::rsp_item_t push_item,
    output logic                        push_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output i2c_rts_pkg::rsp_item_t      out_item
);
    import i2c_rts_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      spare_valid_reg, spare_valid_next;
    rsp_item_t main_item_reg, main_item_next;
    rsp_item_t spare_item_reg, spare_item_next;
    logic      pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !spare_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_item   = main_item_reg;

    always_comb
    begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_item_next   = main_item_reg;
        spare_item_next  = spare_item_reg;
        if (!main_valid_reg || pop)
        begin
            if (spare_valid_reg)
            begin
                // push is held off while the spare is full
                main_item_next   = spare_item_reg;
                spare_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_item_next  = push_item;
            end
        end
        else if (push)
        begin
            spare_valid_next = 1'b1;
            spare_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_item_reg  <= main_item_next;
        spare_item_reg <= spare_item_next;
    end

endmodule

`default_nettype wire

[src/i2c_register_transfer_sequencer_top.sv]
// ----------------------------------------------------------------------------
// i2c_register_transfer_sequencer_top
// I2C master register read/write sequencer over a byte-level controller.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | item
//  --------+-----+-------------+---------------------------------------------
//  cmd     | in  | valid/ready | operation, addresses, length, status flags
//  rsp     | out | valid/ready | status, controller actions, read byte, fail
//
//  One item per clock while cmd.ready is high: each cmd item is stepped in the
//  cycle it is accepted and its response lands in the response buffer at that same edge.
//  The phase register loop (state -> step logic -> state) sets that figure.
//  A two-entry response buffer keeps cmd.ready high while one response waits;
//  cmd.ready drops only when both entries hold untaken responses.
//  Reset (rst_n low, async) returns to idle, clears counts and the fail flag.
//
`default_nettype none

module i2c_register_transfer_sequencer_top #(
    parameter int TIMEOUT_TICKS = i2c_rts_pkg::TIMEOUT_TICKS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    i2c_rts_cmd_if.sink    cmd,
    i2c_rts_rsp_if.source  rsp
);
    import i2c_rts_pkg::*;

    logic      cmd_accept;
    logic      buf_ready;
    rsp_item_t step_result;

    // an item is taken whenever the buffer has a free entry
    assign cmd.ready  = buf_ready;
    assign cmd_accept = cmd.valid && buf_ready;

    // phase tracking, wait counting and action decode for one item
    i2c_rts_step #(
        .TIMEOUT_TICKS(TIMEOUT_TICKS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (cmd_accept),
        .item   (cmd.payload),
        .result (step_result)
    );

    // response register with skid entry
    i2c_rts_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_accept),
        .push_item  (step_result),
        .push_ready (buf_ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_item   (rsp.payload)
    );

endmodule

`default_nettype wire

[src/i2c_rts_checker.sv]
// ----------------------------------------------------------------------------
// i2c_rts_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rts_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cmd_valid,
    input wire logic                   cmd_ready,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire i2c_rts_pkg::rsp_item_t rsp_payload
);
    import i2c_rts_pkg::*;

    logic seen_fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fail_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready && rsp_payload.fail_flag)
        begin
            seen_fail_reg <= 1'b1;
        end
    end

    // fail flag never clears once delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && seen_fail_reg) |-> rsp_payload.fail_flag)
    else $error("fail flag cleared after a delivered failure");

    // every accepted item shows a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> rsp_valid)
    else $error("accepted item produced no response");

    // input stalls only after the response side stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> $past(rsp_valid && !rsp_ready))
    else $error("input stalled without output back-pressure");

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled response changed");

endmodule

bind i2c_register_transfer_sequencer_top i2c_rts_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire
